// ===== rtl/epws_pkg.sv =====
// Package for the EEPROM page write scheduler: item types, codes, sizes.
// No dependencies.
package epws_pkg;

  localparam int NumClients = 6;
  localparam int PageBytes  = 32;
  localparam int AddrLimit  = 8192;
  localparam int CliW       = 3;
  localparam int QDepth     = 2;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_TICK  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  localparam logic [1:0] RESP_OK    = 2'd0;
  localparam logic [1:0] RESP_BUSY  = 2'd1;
  localparam logic [1:0] RESP_RANGE = 2'd2;
  localparam logic [1:0] RESP_ERROR = 2'd3;

  localparam logic [1:0] ST_READY   = 2'd0;
  localparam logic [1:0] ST_WORKING = 2'd1;
  localparam logic [1:0] ST_DONE    = 2'd2;
  localparam logic [1:0] ST_FAIL    = 2'd3;

  typedef struct packed {
    logic [1:0]      func;
    logic [CliW-1:0] client;
    logic [15:0]     address;
    logic [15:0]     length;
    logic [15:0]     data_base;
    logic            hw_ok;
  } in_item_t;

  // classified item handed from front to back
  typedef struct packed {
    in_item_t   item;
    logic       cli_ok;
    logic       in_range;
  } cls_item_t;

  typedef struct packed {
    logic [1:0]      response;
    logic            write_issue;
    logic [15:0]     seg_address;
    logic [15:0]     seg_count;
    logic [15:0]     seg_data;
    logic            read_issue;
    logic            done_notify;
    logic [CliW-1:0] done_client;
    logic            rearm_timer;
    logic            client_free;
    logic [1:0]      client_status;
  } out_item_t;

endpackage

// ===== rtl/eeprom_page_write_scheduler.sv =====
// Top level of the EEPROM page write scheduler: front queue plus back end.
// Depends on epws_pkg, epws_front, epws_back.
//
//  channel | handshake        | payload
//  input   | push / full      | in_item (in_item_t)
//  result  | pop / empty      | out_item (out_item_t)
//
// An accepted item is written into the front queue, taken by the back end when
// the result register is free or being popped, and registered there onto the
// result ports; one item is retired per cycle when pop keeps up.
// The back end updates client and slot state in the same step as it registers the result.
// Reset (rst, synchronous) clears client status, busy and phase flags, slots and the queue.
// A full result register stalls the back end; the two-entry queue then fills.
module eeprom_page_write_scheduler import epws_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_item,
  input  logic      push,
  output logic      full,
  output out_item_t out_item,
  output logic      empty,
  input  logic      pop
);

  cls_item_t q_item;
  logic      q_valid, q_take, res_valid;

  epws_front u_front (
    .clk, .rst, .in_item, .push, .full,
    .q_item, .q_valid, .q_take
  );

  epws_back u_back (
    .clk, .rst, .q_item, .q_valid, .q_take,
    .res(out_item), .res_valid, .res_take(pop)
  );

  assign empty = !res_valid;

endmodule

// ===== rtl/epws_front.sv =====
// Front end: accepts items, checks the client index and the address range,
// and queues classified items for the back end. Uses epws_pkg.
module epws_front import epws_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_item,
  input  logic      push,
  output logic      full,
  output cls_item_t q_item,
  output logic      q_valid,
  input  logic      q_take
);

  cls_item_t  mem [QDepth];
  logic [0:0] wr_ptr, rd_ptr;
  logic [1:0] count;
  cls_item_t  cls;
  logic [16:0] end_addr;

  assign end_addr      = {1'b0, in_item.address} + {1'b0, in_item.length};
  assign cls.item      = in_item;
  assign cls.cli_ok    = ({1'b0, in_item.client} < 4'(NumClients));
  assign cls.in_range  = (end_addr <= 17'(AddrLimit));

  assign full    = (count == 2'(QDepth));
  assign q_valid = (count != 2'd0);
  assign q_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= cls;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + 1'b1;
      if (q_take) rd_ptr <= rd_ptr + 1'b1;
      count <= count + 2'(push && !full) - 2'(q_take);
    end
  end

endmodule

// ===== rtl/epws_back.sv =====
// Back end: per-client state, slot queue, tick scheduling and page clipping.
// Produces one result per item into a registered output. Uses epws_pkg.
module epws_back import epws_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cls_item_t q_item,
  input  logic      q_valid,
  output logic      q_take,
  output out_item_t res,
  output logic      res_valid,
  input  logic      res_take
);

  logic [NumClients-1:0] busy, phase, slot_valid;
  logic [1:0]      st   [NumClients];
  logic [15:0]     naddr [NumClients];
  logic [15:0]     remn  [NumClients];
  logic [15:0]     doff  [NumClients];
  logic [CliW-1:0] slot_owner [NumClients];
  logic            cur_valid;

  in_item_t  it;
  logic [CliW-1:0] c;
  out_item_t o;
  logic      step;

  logic            pick_found;
  logic [CliW-1:0] pick;
  logic            free_found;
  logic [CliW-1:0] free_idx;
  logic [16:0]     seg;
  logic [15:0]     rem_left;

  assign it     = q_item.item;
  assign c      = q_item.cli_ok ? it.client : '0;
  assign q_take = q_valid && (!res_valid || res_take);
  assign step   = q_take;

  always_comb begin
    pick_found = 1'b0;
    pick       = '0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NumClients - 1; i >= 0; i--) begin
      if (slot_valid[i] && ({1'b0, slot_owner[i]} < 4'(NumClients))) begin
        pick_found = 1'b1;
        pick       = slot_owner[i];
      end
      if (!slot_valid[i]) begin
        free_found = 1'b1;
        free_idx   = CliW'(i);
      end
    end
  end

  // page clip: bytes left in the page, bounded by the remaining count
  always_comb begin
    seg = 17'(PageBytes) - 17'(naddr[pick] % PageBytes);
    if (seg >= {1'b0, remn[pick]}) seg = {1'b0, remn[pick]};
    rem_left = remn[pick] - seg[15:0];
  end

  always_comb begin
    o = '0;
    case (func_t'(it.func))
      FUNC_WRITE: begin
        if (!q_item.cli_ok) o.response = RESP_ERROR;
        else if (!q_item.in_range) o.response = RESP_RANGE;
        else if (busy[c]) o.response = RESP_BUSY;
        else o.rearm_timer = 1'b1;
      end
      FUNC_READ: begin
        if (!q_item.cli_ok) o.response = RESP_ERROR;
        else if (busy[c] || cur_valid) o.response = RESP_BUSY;
        else begin
          o.seg_address = it.address;
          o.seg_count   = it.length;
          o.seg_data    = it.data_base;
          o.read_issue  = 1'b1;
          o.response    = it.hw_ok ? RESP_OK : RESP_ERROR;
        end
      end
      FUNC_TICK: begin
        if (pick_found) begin
          o.rearm_timer = 1'b1;
          if (phase[pick]) begin
            o.write_issue = 1'b1;
            o.seg_address = naddr[pick];
            o.seg_count   = seg[15:0];
            o.seg_data    = doff[pick];
          end else begin
            for (int i = 0; i < NumClients; i++) begin
              if (slot_valid[i] && slot_owner[i] == pick) begin
                o.done_notify = 1'b1;
                o.done_client = pick;
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  // status of the addressed client after this item
  logic            nbusy;
  logic [1:0]      nst;
  always_comb begin
    nbusy = busy[c];
    nst   = st[c];
    case (func_t'(it.func))
      FUNC_WRITE: if (q_item.cli_ok && q_item.in_range && !busy[c]) begin
        nbusy = 1'b1;
        nst   = ST_WORKING;
      end
      FUNC_READ: if (q_item.cli_ok && !busy[c] && !cur_valid) begin
        nbusy = 1'b0;
        nst   = it.hw_ok ? ST_DONE : ST_FAIL;
      end
      FUNC_TICK: if (pick_found && pick == c) begin
        if (phase[pick]) begin
          if (!it.hw_ok) nst = ST_FAIL;
          else if (rem_left == 16'd0) nst = ST_DONE;
        end else begin
          nbusy = 1'b0;
        end
      end
      default: ;
    endcase
  end

  out_item_t res_next;
  always_comb begin
    res_next               = o;
    res_next.client_free   = q_item.cli_ok && !nbusy;
    res_next.client_status = q_item.cli_ok ? nst : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res <= res_next;
      case (func_t'(it.func))
        FUNC_WRITE: if (q_item.cli_ok && q_item.in_range && !busy[c]) begin
          naddr[c] <= it.address;
          remn[c]  <= it.length;
          doff[c]  <= it.data_base;
        end
        FUNC_READ: if (q_item.cli_ok && !busy[c] && !cur_valid) begin
          naddr[c] <= it.address;
        end
        FUNC_TICK: if (pick_found && phase[pick] && it.hw_ok) begin
          remn[pick] <= rem_left;
          if (rem_left != 16'd0) begin
            naddr[pick] <= naddr[pick] + seg[15:0];
            doff[pick]  <= doff[pick] + seg[15:0];
          end
        end
        default: ;
      endcase
    end
    if (rst) begin
      res_valid  <= 1'b0;
      busy       <= '0;
      phase      <= '0;
      slot_valid <= '0;
      cur_valid  <= 1'b0;
      for (int i = 0; i < NumClients; i++) begin
        st[i]         <= ST_READY;
        slot_owner[i] <= '0;
      end
    end else begin
      if (step) res_valid <= 1'b1;
      else if (res_take) res_valid <= 1'b0;
      if (step) begin
        case (func_t'(it.func))
          FUNC_WRITE: if (q_item.cli_ok && q_item.in_range && !busy[c]) begin
            busy[c]  <= 1'b1;
            st[c]    <= ST_WORKING;
            phase[c] <= 1'b1;
            if (free_found) begin
              slot_valid[free_idx] <= 1'b1;
              slot_owner[free_idx] <= c;
            end
          end
          FUNC_READ: if (q_item.cli_ok && !busy[c] && !cur_valid) begin
            busy[c] <= 1'b0;
            st[c]   <= nst;
          end
          FUNC_TICK: begin
            cur_valid <= pick_found && phase[pick];
            if (pick_found) begin
              if (phase[pick]) begin
                if (!it.hw_ok || rem_left == 16'd0) begin
                  phase[pick] <= 1'b0;
                  st[pick]    <= it.hw_ok ? ST_DONE : ST_FAIL;
                end
              end else begin
                busy[pick] <= 1'b0;
                for (int i = 0; i < NumClients; i++) begin
                  if (slot_valid[i] && slot_owner[i] == pick) begin
                    slot_valid[i] <= 1'b0;
                    slot_owner[i] <= '0;
                  end
                end
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for the EEPROM page write scheduler: directed table, then random items.
// Depends on epws_pkg and eeprom_page_write_scheduler.
`timescale 1ns / 1ps

module tb_top;
  import epws_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  in_item_t  in_item = '0;
  logic      push = 1'b0;
  logic      full;
  out_item_t out_item;
  logic      empty;
  logic      pop = 1'b0;

  eeprom_page_write_scheduler DUT (
    .clk(clk), .rst(rst), .in_item(in_item), .push(push), .full(full),
    .out_item(out_item), .empty(empty), .pop(pop)
  );

  always #10 clk = ~clk;

  // scheduler shadow state
  logic        busy_q [NumClients];
  logic        phase_q [NumClients];
  logic [1:0]  status_q [NumClients];
  logic [15:0] next_addr_q [NumClients];
  logic [15:0] remain_q [NumClients];
  logic [15:0] offset_q [NumClients];
  logic        slot_v_q [NumClients];
  logic [2:0]  slot_own_q [NumClients];
  logic        cur_v_q;
  logic [2:0]  cur_own_q;

  out_item_t pending_results[$];
  int        errors = 0;
  int        n_items = 0;
  int        n_segments = 0;
  int        n_retired = 0;

  function automatic out_item_t schedule_step(in_item_t it);
    out_item_t   o;
    logic        ok_cli;
    int          c;
    logic [16:0] endp;
    logic [15:0] seg;
    o = '0;
    ok_cli = it.client < NumClients;
    c = ok_cli ? int'(it.client) : 0;
    case (func_t'(it.func))
      FUNC_WRITE: begin
        endp = {1'b0, it.address} + {1'b0, it.length};
        if (!ok_cli) o.response = RESP_ERROR;
        else if (endp > AddrLimit) o.response = RESP_RANGE;
        else if (busy_q[c]) o.response = RESP_BUSY;
        else begin
          busy_q[c] = 1'b1;
          next_addr_q[c] = it.address;
          remain_q[c] = it.length;
          offset_q[c] = it.data_base;
          status_q[c] = ST_WORKING;
          phase_q[c] = 1'b1;
          for (int i = 0; i < NumClients; i++)
            if (!slot_v_q[i]) begin
              slot_v_q[i] = 1'b1;
              slot_own_q[i] = 3'(c);
              break;
            end
          o.rearm_timer = 1'b1;
        end
      end
      FUNC_READ: begin
        if (!ok_cli) o.response = RESP_ERROR;
        else if (busy_q[c] || cur_v_q) o.response = RESP_BUSY;
        else begin
          next_addr_q[c] = it.address;
          o.seg_address = it.address;
          o.seg_count = it.length;
          o.seg_data = it.data_base;
          o.read_issue = 1'b1;
          status_q[c] = it.hw_ok ? ST_DONE : ST_FAIL;
          o.response = it.hw_ok ? RESP_OK : RESP_ERROR;
          busy_q[c] = 1'b0;
        end
      end
      FUNC_TICK: begin
        cur_v_q = 1'b0;
        for (int i = 0; i < NumClients; i++)
          if (slot_v_q[i] && slot_own_q[i] < NumClients) begin
            cur_v_q = 1'b1;
            cur_own_q = slot_own_q[i];
            break;
          end
        if (cur_v_q) begin
          int k;
          k = cur_own_q;
          if (phase_q[k]) begin
            seg = 16'(PageBytes - (next_addr_q[k] % PageBytes));
            if (seg >= remain_q[k]) seg = remain_q[k];
            o.write_issue = 1'b1;
            o.seg_address = next_addr_q[k];
            o.seg_count = seg;
            o.seg_data = offset_q[k];
            o.rearm_timer = 1'b1;
            n_segments++;
            if (it.hw_ok) begin
              remain_q[k] = remain_q[k] - seg;
              if (remain_q[k] != 0) begin
                next_addr_q[k] = next_addr_q[k] + seg;
                offset_q[k] = offset_q[k] + seg;
              end else begin
                phase_q[k] = 1'b0;
                status_q[k] = ST_DONE;
              end
            end else begin
              phase_q[k] = 1'b0;
              status_q[k] = ST_FAIL;
            end
          end else begin
            busy_q[k] = 1'b0;
            for (int i = 0; i < NumClients; i++)
              if (slot_v_q[i] && slot_own_q[i] == k) begin
                o.done_notify = 1'b1;
                o.done_client = 3'(k);
                slot_v_q[i] = 1'b0;
                slot_own_q[i] = '0;
                n_retired++;
              end
            cur_v_q = 1'b0;
            o.rearm_timer = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (ok_cli) begin
      o.client_free = !busy_q[c];
      o.client_status = status_q[c];
    end
    return o;
  endfunction

  // directed rows; a hard-typed expectation is used where chk_lit is set
  typedef struct {
    in_item_t  it;
    logic      chk_lit;
    out_item_t lit;
  } dir_row_t;

  function automatic in_item_t mk(func_t f, int c, int a, int l, int d, bit ok);
    in_item_t it;
    it.func = f;
    it.client = 3'(c);
    it.address = 16'(a);
    it.length = 16'(l);
    it.data_base = 16'(d);
    it.hw_ok = ok;
    return it;
  endfunction

  function automatic out_item_t resp_only(logic [1:0] r, logic free, logic [1:0] st);
    out_item_t o;
    o = '0;
    o.response = r;
    o.client_free = free;
    o.client_status = st;
    return o;
  endfunction

  dir_row_t dir_rows[$];

  task automatic send_item(in_item_t it, logic chk_lit, out_item_t lit);
    out_item_t e;
    push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    e = schedule_step(it);
    if (chk_lit && e != lit) begin
      $display("%0t: table row disagrees with predictor: table %p predictor %p",
               $time, lit, e);
      errors++;
    end
    pending_results.push_back(e);
    n_items++;
    @(negedge clk);
  endtask

  // receiver: accepts on rising edge, drives pop at falling edge
  initial begin
    int mode;
    mode = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_item);
          errors++;
        end else begin
          out_item_t e;
          e = pending_results.pop_front();
          if (out_item != e) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, out_item);
            errors++;
          end
        end
      end
      @(negedge clk);
      if ($urandom_range(0, 199) == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: pop <= 1'b1;
        1: pop <= ($urandom_range(0, 3) != 0);
        2: pop <= ($urandom_range(0, 1) != 0);
        default: pop <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  function automatic in_item_t rand_item();
    in_item_t it;
    int r;
    r = $urandom_range(0, 99);
    it.hw_ok = ($urandom_range(0, 9) != 0);
    it.client = 3'($urandom_range(0, 9) == 0 ? $urandom_range(6, 7) : $urandom_range(0, 5));
    it.data_base = 16'($urandom);
    if (r < 30) begin
      it.func = FUNC_WRITE;
      if ($urandom_range(0, 9) == 0) begin
        it.address = 16'($urandom);
        it.length = 16'($urandom);
      end else begin
        it.address = 16'($urandom_range(0, AddrLimit - 1));
        it.length = 16'($urandom_range(0, 100));
        if (int'(it.address) + int'(it.length) > AddrLimit)
          it.address = 16'(AddrLimit - it.length);
      end
    end else if (r < 45) begin
      it.func = FUNC_READ;
      it.address = 16'($urandom);
      it.length = 16'($urandom);
    end else if (r < 97) begin
      it.func = FUNC_TICK;
      it.address = 16'($urandom);
      it.length = 16'($urandom);
    end else begin
      it.func = FUNC_NOP;
      it.address = 16'($urandom);
      it.length = 16'($urandom);
    end
    return it;
  endfunction

  initial begin
    out_item_t none;
    int burst;
    none = '0;
    for (int i = 0; i < NumClients; i++) begin
      busy_q[i] = 0; phase_q[i] = 0; status_q[i] = ST_READY;
      next_addr_q[i] = 0; remain_q[i] = 0; offset_q[i] = 0;
      slot_v_q[i] = 0; slot_own_q[i] = 0;
    end
    cur_v_q = 0; cur_own_q = 0;

    dir_rows.push_back('{mk(FUNC_TICK, 0, 0, 0, 0, 1), 1, resp_only(RESP_OK, 1, ST_READY)});
    dir_rows.push_back('{mk(FUNC_WRITE, 7, 0, 0, 0, 1), 1, none});
    none.response = RESP_ERROR;
    dir_rows[1].lit = none;
    dir_rows.push_back('{mk(FUNC_READ, 6, 0, 0, 0, 1), 1, none});
    dir_rows.push_back('{mk(FUNC_WRITE, 0, 'hFFFF, 'hFFFF, 0, 1), 1,
                         resp_only(RESP_RANGE, 1, ST_READY)});
    dir_rows.push_back('{mk(FUNC_WRITE, 1, 8191, 2, 0, 1), 1,
                         resp_only(RESP_RANGE, 1, ST_READY)});
    dir_rows.push_back('{mk(FUNC_NOP, 2, 'hFFFF, 'hFFFF, 'hFFFF, 1), 1,
                         resp_only(RESP_OK, 1, ST_READY)});
    dir_rows.push_back('{mk(FUNC_READ, 2, 'hFFFF, 'hFFFF, 'hFFFF, 0), 0, none});
    dir_rows.push_back('{mk(FUNC_READ, 3, 100, 8, 'h1234, 1), 0, none});
    dir_rows.push_back('{mk(FUNC_WRITE, 0, 8190, 2, 'hFFF0, 1), 0, none});
    dir_rows.push_back('{mk(FUNC_WRITE, 0, 0, 0, 0, 1), 1,
                         resp_only(RESP_BUSY, 0, ST_WORKING)});
    dir_rows.push_back('{mk(FUNC_WRITE, 1, 0, 0, 0, 1), 0, none});
    dir_rows.push_back('{mk(FUNC_WRITE, 5, 20, 80, 'hFFF8, 1), 0, none});
    dir_rows.push_back('{mk(FUNC_READ, 4, 0, 0, 0, 1), 0, none});
    for (int i = 0; i < 4; i++)
      dir_rows.push_back('{mk(FUNC_TICK, 0, 0, 0, 0, 1), 0, none});
    dir_rows.push_back('{mk(FUNC_READ, 4, 0, 0, 0, 1), 0, none});
    dir_rows.push_back('{mk(FUNC_TICK, 5, 0, 0, 0, 0), 0, none});
    for (int i = 0; i < 4; i++)
      dir_rows.push_back('{mk(FUNC_TICK, i, 0, 0, 0, 1), 0, none});

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].chk_lit, dir_rows[i].lit);

    while (n_items < 1725) begin
      burst = $urandom_range(1, 30);
      repeat (burst) send_item(rand_item(), 1'b0, none);
      if ($urandom_range(0, 2) != 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
    push <= 1'b0;

    while (pending_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("%0d items sent; %0d page segments issued, %0d writes retired",
             n_items, n_segments, n_retired);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule
